### sv/dedup_packet_fifo_with_range_count_defines.svh
// ----------------------------------------------------------------------------
// dedup packet fifo assertion macros
// shared property wrappers, sampled on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef DEDUP_PACKET_FIFO_WITH_RANGE_COUNT_DEFINES_SVH
`define DEDUP_PACKET_FIFO_WITH_RANGE_COUNT_DEFINES_SVH

// same-cycle implication
`define DPF_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DPF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/dpf_pkg.sv
// ----------------------------------------------------------------------------
// dpf_pkg
// shared sizes, request and result types and pointer helpers of the
// dedup packet fifo
// ----------------------------------------------------------------------------
package dpf_pkg;

    localparam int DEPTH      = 64;
    localparam int ID_BITS    = 16;
    localparam int TIME_BITS  = 32;
    localparam int PTR_BITS   = $clog2(DEPTH);
    localparam int OCC_BITS   = $clog2(DEPTH + 1);
    localparam int LIMIT_BITS = 7;
    localparam int COUNT_BITS = 7;
    localparam int LIM_W      = (OCC_BITS > LIMIT_BITS) ? OCC_BITS : LIMIT_BITS;
    localparam int SUM_W      = OCC_BITS + 1;
    localparam int ENTRY_BITS = 2 * ID_BITS + TIME_BITS;

    // input tdata layout
    localparam int IN_SRC_LSB    = 0;
    localparam int IN_DST_LSB    = ID_BITS;
    localparam int IN_TS_LSB     = 2 * ID_BITS;
    localparam int IN_LO_LSB     = 2 * ID_BITS + TIME_BITS;
    localparam int IN_HI_LSB     = 2 * ID_BITS + 2 * TIME_BITS;
    localparam int IN_FIELD_BITS = 2 * ID_BITS + 3 * TIME_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_CNT_LSB    = 2 * ID_BITS + TIME_BITS;
    localparam int OUT_FIELD_BITS = OUT_CNT_LSB + COUNT_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int REQ_BITS  = 2;
    localparam int FLAG_BITS = 2;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_ADD   = 2'd0,
        REQ_FWD   = 2'd1,
        REQ_COUNT = 2'd2,
        REQ_NONE  = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        req_kind_t             kind;
        logic [ID_BITS-1:0]    src;
        logic [ID_BITS-1:0]    dst;
        logic [TIME_BITS-1:0]  ts;
        logic [TIME_BITS-1:0]  lo;
        logic [TIME_BITS-1:0]  hi;
    } req_t;

    typedef struct packed {
        logic                  accepted;
        logic                  pkt_valid;
        logic [ID_BITS-1:0]    src;
        logic [ID_BITS-1:0]    dst;
        logic [TIME_BITS-1:0]  ts;
        logic [COUNT_BITS-1:0] count;
    } res_t;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] ptr);
        logic [PTR_BITS-1:0] r;
        if (ptr == PTR_BITS'(DEPTH - 1))
            r = '0;
        else
            r = ptr + PTR_BITS'(1);
        return r;
    endfunction

    // ptr + off modulo DEPTH, off never above DEPTH
    function automatic logic [PTR_BITS-1:0] ptr_add(input logic [PTR_BITS-1:0] ptr,
                                                    input logic [OCC_BITS-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(ptr) + SUM_W'(off);
        if (s >= SUM_W'(DEPTH))
            s = s - SUM_W'(DEPTH);
        return s[PTR_BITS-1:0];
    endfunction

endpackage

### sv/dedup_packet_fifo_with_range_count.sv
// ----------------------------------------------------------------------------
// dedup_packet_fifo_with_range_count
// bounded packet fifo with duplicate filter, pop and range count
// ----------------------------------------------------------------------------
// One request is worked at a time and each gives one response. An add or
// count request on a non-empty buffer reads every held entry once from the
// single entry ram, one read a cycle, then finishes with the response. A
// forward reads the oldest entry in the pop state, then finishes; a request
// on an empty buffer or of unknown type skips the reads. The response sits
// in an output register, so the next request is taken while it waits; a
// request only stalls in the finish state while that register is still full.
// Entries are written in the finish state, before the next request reads them.
module dedup_packet_fifo_with_range_count (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // src_id, dst_id, time_stamp, range_start, range_end
    input  logic [dpf_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // req_type
    input  logic [dpf_pkg::REQ_BITS-1:0]       s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_src, out_dst, out_time, match_count, zero pad
    output logic [dpf_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    // accepted, pkt_valid
    output logic [dpf_pkg::FLAG_BITS-1:0]      m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dpf_pkg::LIMIT_BITS-1:0]     cfg_data
);

    import dpf_pkg::*;

    req_t                   req;
    res_t                   res;
    logic                   rd_en;
    logic [PTR_BITS-1:0]    rd_addr;
    logic [ENTRY_BITS-1:0]  rd_data;
    logic                   wr_en;
    logic [PTR_BITS-1:0]    wr_addr;
    logic [ENTRY_BITS-1:0]  wr_data;

    assign req.kind = req_kind_t'(s_tuser);
    assign req.src  = s_tdata[IN_SRC_LSB +: ID_BITS];
    assign req.dst  = s_tdata[IN_DST_LSB +: ID_BITS];
    assign req.ts   = s_tdata[IN_TS_LSB +: TIME_BITS];
    assign req.lo   = s_tdata[IN_LO_LSB +: TIME_BITS];
    assign req.hi   = s_tdata[IN_HI_LSB +: TIME_BITS];

    assign m_tdata = OUT_DATA_BITS'({res.count, res.ts, res.dst, res.src});
    assign m_tuser = {res.pkt_valid, res.accepted};

    dpf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    dpf_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

### sv/dpf_ram.sv
// ----------------------------------------------------------------------------
// dpf_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module dpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/dpf_ctrl.sv
// ----------------------------------------------------------------------------
// dpf_ctrl
// request sequencer: ring pointers, entry scan over the ram, result register
// ----------------------------------------------------------------------------
module dpf_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  dpf_pkg::req_t                   req,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dpf_pkg::LIMIT_BITS-1:0]  cfg_data,
    output logic                            res_valid,
    input  logic                            res_ready,
    output dpf_pkg::res_t                   res,
    output logic                            rd_en,
    output logic [dpf_pkg::PTR_BITS-1:0]    rd_addr,
    input  logic [dpf_pkg::ENTRY_BITS-1:0]  rd_data,
    output logic                            wr_en,
    output logic [dpf_pkg::PTR_BITS-1:0]    wr_addr,
    output logic [dpf_pkg::ENTRY_BITS-1:0]  wr_data
);

    import dpf_pkg::*;

    state_t                 state_reg, state_next;
    req_t                   req_reg, req_next;
    logic [PTR_BITS-1:0]    head_reg, head_next;
    logic [OCC_BITS-1:0]    occ_reg, occ_next;
    logic [LIM_W-1:0]       limit_reg, limit_next;
    logic [PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [OCC_BITS-1:0]    left_reg, left_next;
    logic                   hit_reg, hit_next;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [ENTRY_BITS-1:0]  pop_reg, pop_next;
    logic                   out_valid_reg, out_valid_next;
    res_t                   out_reg, out_next;

    logic [ID_BITS-1:0]     ent_src;
    logic [ID_BITS-1:0]     ent_dst;
    logic [TIME_BITS-1:0]   ent_ts;
    logic                   add_match;
    logic                   cnt_match;
    logic [LIM_W-1:0]       eff_limit;
    logic                   evict;
    logic [PTR_BITS-1:0]    add_head;
    logic [OCC_BITS-1:0]    add_occ;

    assign ent_src = rd_data[ID_BITS-1:0];
    assign ent_dst = rd_data[2*ID_BITS-1:ID_BITS];
    assign ent_ts  = rd_data[ENTRY_BITS-1:2*ID_BITS];

    assign add_match = (ent_src == req_reg.src) && (ent_dst == req_reg.dst)
                       && (ent_ts == req_reg.ts);
    assign cnt_match = (ent_dst == req_reg.dst) && (ent_ts >= req_reg.lo)
                       && (ent_ts <= req_reg.hi);

    always_comb
    begin
        if (limit_reg == '0)
            eff_limit = LIM_W'(1);
        else if (limit_reg > LIM_W'(DEPTH))
            eff_limit = LIM_W'(DEPTH);
        else
            eff_limit = limit_reg;
    end

    // buffer at its limit drops its oldest entry before the append
    assign evict    = LIM_W'(occ_reg) >= eff_limit;
    assign add_head = evict ? ptr_inc(head_reg) : head_reg;
    assign add_occ  = evict ? occ_reg - OCC_BITS'(1) : occ_reg;

    assign req_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign wr_addr   = ptr_add(add_head, add_occ);
    assign wr_data   = {req_reg.ts, req_reg.dst, req_reg.src};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            limit_reg     <= LIM_W'(DEPTH);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rd_ptr_reg <= rd_ptr_next;
        left_reg   <= left_next;
        hit_reg    <= hit_next;
        cnt_reg    <= cnt_next;
        pop_reg    <= pop_next;
        out_reg    <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        head_next      = head_reg;
        occ_next       = occ_reg;
        limit_next     = limit_reg;
        rd_ptr_next    = rd_ptr_reg;
        left_next      = left_reg;
        hit_next       = hit_reg;
        cnt_next       = cnt_reg;
        pop_next       = pop_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        wr_en          = 1'b0;

        if (cfg_valid)
        begin
            limit_next = LIM_W'(cfg_data);
        end

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    hit_next = 1'b0;
                    cnt_next = '0;
                    if ((req.kind == REQ_ADD || req.kind == REQ_COUNT) && occ_reg != '0)
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = head_reg;
                        rd_ptr_next = ptr_inc(head_reg);
                        left_next   = occ_reg - OCC_BITS'(1);
                        state_next  = ST_SCAN;
                    end
                    else if (req.kind == REQ_FWD && occ_reg != '0)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = head_reg;
                        state_next = ST_POP;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SCAN:
            begin
                // rd_data holds the entry requested last cycle
                if (req_reg.kind == REQ_ADD && add_match)
                begin
                    hit_next = 1'b1;
                end
                if (req_reg.kind == REQ_COUNT && cnt_match && cnt_reg != '1)
                begin
                    cnt_next = cnt_reg + COUNT_BITS'(1);
                end
                if (left_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr     = rd_ptr_reg;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    left_next   = left_reg - OCC_BITS'(1);
                end
            end

            ST_POP:
            begin
                pop_next   = rd_data;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    state_next     = ST_IDLE;
                    unique case (req_reg.kind)
                        REQ_ADD:
                        begin
                            if (!hit_reg)
                            begin
                                wr_en             = 1'b1;
                                head_next         = add_head;
                                occ_next          = add_occ + OCC_BITS'(1);
                                out_next.accepted = 1'b1;
                            end
                        end
                        REQ_FWD:
                        begin
                            if (occ_reg != '0)
                            begin
                                out_next.pkt_valid = 1'b1;
                                out_next.src       = pop_reg[ID_BITS-1:0];
                                out_next.dst       = pop_reg[2*ID_BITS-1:ID_BITS];
                                out_next.ts        = pop_reg[ENTRY_BITS-1:2*ID_BITS];
                                head_next          = ptr_inc(head_reg);
                                occ_next           = occ_reg - OCC_BITS'(1);
                            end
                        end
                        REQ_COUNT:
                        begin
                            out_next.count = cnt_reg;
                        end
                        REQ_NONE:
                        begin
                            out_next = '0;
                        end
                        default:
                        begin
                            out_next = '0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/dpf_checker.sv
// ----------------------------------------------------------------------------
// dpf_checker
// port level checks of the dedup packet fifo, bound to the top level
// ----------------------------------------------------------------------------
`include "dedup_packet_fifo_with_range_count_defines.svh"

module dpf_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [dpf_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    input  logic [dpf_pkg::FLAG_BITS-1:0]      m_tuser
);

    import dpf_pkg::*;

    // a stalled response holds
    `DPF_ASSERT_NEXT(a_resp_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "response changed while stalled")

    // add and forward flags never on the same response
    `DPF_ASSERT_NOW(a_flags_excl, m_tvalid, !(m_tuser[0] && m_tuser[1]),
        "accepted and pkt_valid both set")

    // packet fields are zero unless a packet was popped
    `DPF_ASSERT_NOW(a_pkt_zero, m_tvalid && !m_tuser[1], m_tdata[OUT_CNT_LSB-1:0] == '0,
        "packet fields set without pop")

    // count is zero on add and forward responses
    `DPF_ASSERT_NOW(a_cnt_zero, m_tvalid && (m_tuser[0] || m_tuser[1]),
        m_tdata[OUT_CNT_LSB+COUNT_BITS-1:OUT_CNT_LSB] == '0, "count set on non-count response")

endmodule

bind dedup_packet_fifo_with_range_count dpf_checker u_dpf_checker (.*);

### test/dedup_packet_fifo_with_range_count_tb.sv
// ----------------------------------------------------------------------------
// dedup_packet_fifo_with_range_count_tb
// Drives add, forward, count and unknown requests into the packet fifo under
// random idling on both sides, and changes the packet limit between phases,
// also while packets are held. A packet store kept here works out the answer
// to every accepted request, and each response is checked field by field
// against the oldest expected one.
// ----------------------------------------------------------------------------
module dedup_packet_fifo_with_range_count_tb;

    import dpf_pkg::*;

    localparam int RUN_LIMIT    = 2000000;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 70;
    localparam int PHASE_ITEMS  = 215;
    localparam int RECENT_MAX   = 96;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        logic [ID_BITS-1:0]   src;
        logic [ID_BITS-1:0]   dst;
        logic [TIME_BITS-1:0] ts;
    } pkt_key_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata   = '0;
    logic [REQ_BITS-1:0]      s_tuser   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic [FLAG_BITS-1:0]     m_tuser;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [LIMIT_BITS-1:0]    cfg_data  = '0;

    // packet store as the block should hold it
    logic [ID_BITS-1:0]       pkt_src  [DEPTH];
    logic [ID_BITS-1:0]       pkt_dst  [DEPTH];
    logic [TIME_BITS-1:0]     pkt_time [DEPTH];
    int                       oldest_slot = 0;
    int                       held_count  = 0;
    logic [LIMIT_BITS-1:0]    limit_reg   = LIMIT_BITS'(DEPTH);

    req_t                     request_q[$];
    res_t                     response_q[$];
    pkt_key_t                 recent_pkts[$];
    req_t                     offered_req;
    req_t                     next_req;

    int send_gap = 0, send_run = 0;
    int recv_stall = 0, recv_run = 0, recv_hold = 0;
    int responses_seen = 0;
    int error_count = 0;
    int cycle_count = 0;
    int n_stored = 0, n_dup = 0, n_pop = 0, n_pop_empty = 0;
    int n_count = 0, n_count_hit = 0, max_count = 0, n_unknown = 0, n_limits = 0;

    dedup_packet_fifo_with_range_count u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // answer to one request, updating the packet store
    function automatic res_t serve_request(input req_t rq);
        res_t r;
        int   k;
        int   slot;
        int   lim;
        int   hits;
        logic dup;
        r = '0;
        case (rq.kind)
            REQ_ADD:
            begin
                dup = 1'b0;
                for (k = 0; k < held_count; k++)
                begin
                    slot = (oldest_slot + k) % DEPTH;
                    if (pkt_src[slot] == rq.src && pkt_dst[slot] == rq.dst &&
                        pkt_time[slot] == rq.ts)
                        dup = 1'b1;
                end
                if (!dup)
                begin
                    if (limit_reg == 0)
                        lim = 1;
                    else if (int'(limit_reg) > DEPTH)
                        lim = DEPTH;
                    else
                        lim = int'(limit_reg);
                    // at the limit: the oldest packet goes without notice
                    if (held_count >= lim)
                    begin
                        oldest_slot = (oldest_slot + 1) % DEPTH;
                        held_count--;
                    end
                    slot = (oldest_slot + held_count) % DEPTH;
                    pkt_src[slot]  = rq.src;
                    pkt_dst[slot]  = rq.dst;
                    pkt_time[slot] = rq.ts;
                    held_count++;
                    r.accepted = 1'b1;
                end
            end
            REQ_FWD:
            begin
                if (held_count != 0)
                begin
                    r.pkt_valid = 1'b1;
                    r.src       = pkt_src[oldest_slot];
                    r.dst       = pkt_dst[oldest_slot];
                    r.ts        = pkt_time[oldest_slot];
                    oldest_slot = (oldest_slot + 1) % DEPTH;
                    held_count--;
                end
            end
            REQ_COUNT:
            begin
                hits = 0;
                for (k = 0; k < held_count; k++)
                begin
                    slot = (oldest_slot + k) % DEPTH;
                    if (pkt_dst[slot] == rq.dst && pkt_time[slot] >= rq.lo &&
                        pkt_time[slot] <= rq.hi)
                        hits++;
                end
                if (hits > 127)
                    hits = 127;
                r.count = COUNT_BITS'(hits);
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // idle length: mostly short, a few long, now and then a run with none
    function automatic int idle_len(inout int run_left);
        int r;
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            run_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ID_BITS-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return ID_BITS'($urandom_range(0, 3));
        if (r < 75)
            return {ID_BITS{1'b1}} - ID_BITS'($urandom_range(0, 1));
        return ID_BITS'($urandom);
    endfunction

    function automatic logic [TIME_BITS-1:0] pick_stamp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return TIME_BITS'($urandom_range(0, 7));
        if (r < 65)
            return {TIME_BITS{1'b1}} - TIME_BITS'($urandom_range(0, 3));
        return TIME_BITS'($urandom);
    endfunction

    // adds from small pools so that duplicates and count hits are common
    function automatic req_t random_request();
        req_t     rq;
        pkt_key_t key;
        int       r;
        int       pick;
        rq.kind = REQ_NONE;
        rq.src  = ID_BITS'($urandom);
        rq.dst  = ID_BITS'($urandom);
        rq.ts   = TIME_BITS'($urandom);
        rq.lo   = TIME_BITS'($urandom);
        rq.hi   = TIME_BITS'($urandom);
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            rq.kind = REQ_ADD;
            if (recent_pkts.size() > 0 && $urandom_range(0, 4) == 0)
            begin
                key = recent_pkts[$urandom_range(0, recent_pkts.size() - 1)];
                rq.src = key.src;
                rq.dst = key.dst;
                rq.ts  = key.ts;
            end
            else
            begin
                rq.src = pick_id();
                rq.dst = pick_id();
                rq.ts  = pick_stamp();
                key.src = rq.src;
                key.dst = rq.dst;
                key.ts  = rq.ts;
                recent_pkts.insert(recent_pkts.size(), key);
                if (recent_pkts.size() > RECENT_MAX)
                    void'(recent_pkts.pop_front());
            end
        end
        else if (r < 70)
            rq.kind = REQ_FWD;
        else if (r < 95)
        begin
            rq.kind = REQ_COUNT;
            key = '0;
            if (recent_pkts.size() > 0)
                key = recent_pkts[$urandom_range(0, recent_pkts.size() - 1)];
            rq.dst = ($urandom_range(0, 1) == 0) ? key.dst : pick_id();
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                rq.lo = '0;
                rq.hi = '1;
            end
            else if (pick < 50)
            begin
                // may come out inverted
                rq.lo = TIME_BITS'($urandom_range(0, 8));
                rq.hi = TIME_BITS'($urandom_range(0, 8));
            end
            else if (pick < 70)
            begin
                rq.lo = key.ts;
                rq.hi = key.ts;
            end
            else if (pick < 85)
            begin
                rq.lo = pick_stamp();
                rq.hi = pick_stamp();
            end
        end
        return rq;
    endfunction

    task automatic queue_request(input req_kind_t kind, input logic [ID_BITS-1:0] src,
                                 input logic [ID_BITS-1:0] dst,
                                 input logic [TIME_BITS-1:0] ts,
                                 input logic [TIME_BITS-1:0] lo,
                                 input logic [TIME_BITS-1:0] hi);
        req_t rq;
        rq.kind = kind;
        rq.src  = src;
        rq.dst  = dst;
        rq.ts   = ts;
        rq.lo   = lo;
        rq.hi   = hi;
        request_q.insert(request_q.size(), rq);
    endtask

    // sender pauses until every response is back
    task automatic wait_idle();
        while (request_q.size() != 0 || s_tvalid || response_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(input logic [LIMIT_BITS-1:0] value);
        wait_idle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        limit_reg = value;
        n_limits++;
        cfg_valid <= 1'b0;
    endtask

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        if (error_count < MAX_PRINTS)
            $display("mismatch at response %0d: %s expected %0h got %0h",
                     responses_seen, what, want, got);
        error_count++;
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                response_q.insert(response_q.size(), serve_request(offered_req));
                case (offered_req.kind)
                    REQ_ADD:
                    begin
                        if (response_q[$].accepted)
                            n_stored++;
                        else
                            n_dup++;
                    end
                    REQ_FWD:
                    begin
                        if (response_q[$].pkt_valid)
                            n_pop++;
                        else
                            n_pop_empty++;
                    end
                    REQ_COUNT:
                    begin
                        n_count++;
                        if (response_q[$].count != 0)
                            n_count_hit++;
                        if (int'(response_q[$].count) > max_count)
                            max_count = int'(response_q[$].count);
                    end
                    default:
                        n_unknown++;
                endcase
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    next_req = request_q.pop_front();
                    offered_req <= next_req;
                    s_tdata  <= IN_DATA_BITS'({next_req.hi, next_req.lo, next_req.ts,
                                               next_req.dst, next_req.src});
                    s_tuser  <= next_req.kind;
                    s_tvalid <= 1'b1;
                    send_gap = idle_len(send_run);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // response monitor and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (response_q.size() == 0)
                    flag_mismatch("unexpected response, tdata", 0, longint'(m_tdata[63:0]));
                else
                begin
                    if (m_tuser[0] !== response_q[0].accepted)
                        flag_mismatch("accepted", longint'(response_q[0].accepted),
                                      longint'(m_tuser[0]));
                    if (m_tuser[1] !== response_q[0].pkt_valid)
                        flag_mismatch("pkt_valid", longint'(response_q[0].pkt_valid),
                                      longint'(m_tuser[1]));
                    if (m_tdata[ID_BITS-1:0] !== response_q[0].src)
                        flag_mismatch("out_src", longint'(response_q[0].src),
                                      longint'(m_tdata[ID_BITS-1:0]));
                    if (m_tdata[2*ID_BITS-1:ID_BITS] !== response_q[0].dst)
                        flag_mismatch("out_dst", longint'(response_q[0].dst),
                                      longint'(m_tdata[2*ID_BITS-1:ID_BITS]));
                    if (m_tdata[OUT_CNT_LSB-1:2*ID_BITS] !== response_q[0].ts)
                        flag_mismatch("out_time", longint'(response_q[0].ts),
                                      longint'(m_tdata[OUT_CNT_LSB-1:2*ID_BITS]));
                    if (m_tdata[OUT_FIELD_BITS-1:OUT_CNT_LSB] !== response_q[0].count)
                        flag_mismatch("match_count", longint'(response_q[0].count),
                                      longint'(m_tdata[OUT_FIELD_BITS-1:OUT_CNT_LSB]));
                    void'(response_q.pop_front());
                end
                responses_seen++;
                recv_stall = idle_len(recv_run);
                // long hold-off so the block backs up into its input
                if (responses_seen == 300 || responses_seen == 1400)
                    recv_hold = HOLD_CYCLES;
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                m_tready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, response_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        logic [LIMIT_BITS-1:0] phase_limits[9];
        int p;
        int n;
        phase_limits = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd3, 7'd100, 7'd64, 7'd2, 7'd40};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset limit
        queue_request(REQ_FWD,   '0, '0, '0, '0, '0);   // forward on empty buffer
        queue_request(REQ_COUNT, '0, '0, '0, '0, '1);   // count on empty buffer
        queue_request(REQ_NONE,  '0, '0, '0, '0, '0);
        queue_request(REQ_NONE,  '1, '1, '1, '1, '1);
        queue_request(REQ_ADD,   '0, '0, '0, '0, '0);
        queue_request(REQ_ADD,   '0, '0, '0, '1, '1);   // duplicate
        queue_request(REQ_ADD,   '1, '1, '1, '0, '0);
        queue_request(REQ_ADD,   '1, '1, '1, '1, '1);   // duplicate
        queue_request(REQ_ADD,   '0, '1, '0, '0, '0);   // differs in dst only
        queue_request(REQ_ADD,   '1, '0, '0, '0, '0);   // differs in src only
        queue_request(REQ_COUNT, '0, '1, '0, '0, '1);
        queue_request(REQ_COUNT, '1, '1, '1, 32'd1, 32'hFFFF_FFFE);
        queue_request(REQ_COUNT, '0, '1, '0, '1, '1);
        queue_request(REQ_COUNT, '0, '1, '0, '1, '0);   // inverted range
        queue_request(REQ_COUNT, '1, '0, '1, '0, '0);
        queue_request(REQ_FWD,   '1, '1, '1, '1, '1);
        queue_request(REQ_ADD,   '0, '0, '0, '0, '0);   // popped, so stored again
        repeat (5) queue_request(REQ_FWD, '0, '0, '0, '0, '0);

        // random phases; limits change while packets are held
        for (p = 0; p < 9; p++)
        begin
            set_limit(phase_limits[p]);
            for (n = 0; n < PHASE_ITEMS; n++)
                request_q.insert(request_q.size(), random_request());
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (response_q.size() != 0)
            flag_mismatch("responses missing, count", 0, longint'(response_q.size()));
        $display("covered %0d responses: %0d stored, %0d duplicates, %0d pops, %0d on empty",
                 responses_seen, n_stored, n_dup, n_pop, n_pop_empty);
        $display("%0d counts (%0d nonzero, max %0d), %0d unknown, %0d limit writes",
                 n_count, n_count_hit, max_count, n_unknown, n_limits);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/dpf_pkg.sv
sv/dpf_ram.sv
sv/dpf_ctrl.sv
sv/dedup_packet_fifo_with_range_count.sv
sv/dpf_checker.sv
test/dedup_packet_fifo_with_range_count_tb.sv
